>>> hw/rtl/sfbd_pkg.sv
// shared types and constants for the sprite frame buffer draw block
package sfbd_pkg;

	localparam int unsigned OP_W     = 2;
	localparam int unsigned PIX_W    = 64;
	localparam int unsigned SPRITE_W = 8;
	localparam int unsigned COL_W    = 6;
	localparam int unsigned ROWIN_W  = 5;

	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_DRAW  = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic load;   // capture request and wrap coordinates
		logic rd;     // read the addressed row
		logic wr;     // modify, write back and register the result
	} sfbd_cmd_t;

endpackage

>>> hw/rtl/sfbd_ctrl.sv
// controller state machine for the sprite frame buffer draw block
module sfbd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	output sfbd_pkg::sfbd_cmd_t cmd
);
	import sfbd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_READ  = 3'b010,
		ST_WRITE = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.rd   = 1'b0;
		cmd.wr   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				cmd.wr  = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.wr;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

>>> hw/rtl/sfbd_datapath.sv
// row memory, sprite row xor and collision logic
module sfbd_datapath #(
	parameter int unsigned SCREEN_COLUMNS = 64,
	parameter int unsigned SCREEN_ROWS    = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sfbd_pkg::sfbd_cmd_t             cmd,
	input  logic [sfbd_pkg::OP_W-1:0]       opcode,
	input  logic [sfbd_pkg::COL_W-1:0]      pos_x,
	input  logic [sfbd_pkg::ROWIN_W-1:0]    pos_y,
	input  logic [sfbd_pkg::SPRITE_W-1:0]   row_bits,
	input  logic                            sprite_start,
	output logic                            collision,
	output logic [sfbd_pkg::PIX_W-1:0]      row_pixels
);
	import sfbd_pkg::*;

	localparam int unsigned ROW_AW = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;

	// request registers
	logic [OP_W-1:0]     op_q;
	logic [COL_W-1:0]    px_q;
	logic [ROW_AW-1:0]   py_q;
	logic [SPRITE_W-1:0] bits_q;
	logic                start_q;

	// row storage, valid bits stand in for the reset and clear values
	logic [PIX_W-1:0]       mem_q [SCREEN_ROWS];
	logic [SCREEN_ROWS-1:0] valid_q;
	logic [PIX_W-1:0]       rdata_s1;
	logic                   rvalid_s1;

	logic             collision_q;
	logic [PIX_W-1:0] row_pixels_q;

	logic [6:0]        x_t;
	logic [6:0]        y_t;
	logic [PIX_W-1:0]  row;
	logic [PIX_W-1:0]  mask;
	logic [6:0]        col;
	logic [COL_W-1:0]  bit_idx;

	// wrap coordinates by repeated compare and subtract
	always_comb begin
		x_t = {1'b0, pos_x};
		for (int k = 0; k < 8; k++) begin
			if (x_t >= 7'(SCREEN_COLUMNS)) x_t = x_t - 7'(SCREEN_COLUMNS);
		end
		y_t = {2'b00, pos_y};
		for (int k = 0; k < 4; k++) begin
			if (y_t >= 7'(SCREEN_ROWS)) y_t = y_t - 7'(SCREEN_ROWS);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= opcode;
			px_q    <= x_t[COL_W-1:0];
			py_q    <= y_t[ROW_AW-1:0];
			bits_q  <= row_bits;
			start_q <= sprite_start;
		end
	end

	// sprite mask, column 0 at bit 63
	always_comb begin
		mask    = '0;
		col     = '0;
		bit_idx = '0;
		for (int i = 0; i < SPRITE_W; i++) begin
			col = {1'b0, px_q} + 7'(i);
			if (col >= 7'(SCREEN_COLUMNS)) col = col - 7'(SCREEN_COLUMNS);
			bit_idx = 6'd63 - col[COL_W-1:0];
			if (bits_q[SPRITE_W-1-i]) mask[bit_idx] = 1'b1;
		end
	end

	assign row = rvalid_s1 ? rdata_s1 : '0;

	always_ff @(posedge clk) begin
		if (cmd.rd) rdata_s1 <= mem_q[py_q];
		if (cmd.wr && op_q == OP_DRAW) mem_q[py_q] <= row ^ mask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			if (cmd.rd) rvalid_s1 <= valid_q[py_q];
			if (cmd.wr) begin
				if (op_q == OP_CLEAR) valid_q <= '0;
				else if (op_q == OP_DRAW) valid_q[py_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collision_q <= 1'b0;
		end else if (cmd.wr && op_q == OP_DRAW) begin
			collision_q <= (collision_q & ~start_q) | (|(row & mask));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) row_pixels_q <= (op_q == OP_READ) ? row : '0;
	end

	assign collision  = collision_q;
	assign row_pixels = row_pixels_q;

endmodule

>>> hw/rtl/sprite_frame_buffer_draw.sv
// top level of the monochrome sprite frame buffer draw block
//
// one request channel: opcode, pos_x, pos_y, row_bits and sprite_start are
// taken at a rising edge where start is high and busy is low
// opcodes: clear screen, draw one 8-pixel sprite row by xor, read one row
// one result per request: done pulses for one cycle with collision and
// row_pixels valid in that cycle; the receiver cannot stall, so it must
// take the result in that cycle
// latency: done is high in the third cycle after the accepting edge
// throughput: one request every three cycles; the row memory read is
// registered, so a draw is a read cycle followed by a modify-write cycle,
// and busy drops again in the cycle that done is high
// coordinates wrap modulo the screen size, so do sprite pixels past the edge
// collision accumulates over rows drawn since the last sprite_start row
// reset (arst_n low) empties the screen through per-row valid bits and
// clears collision; a clear request drops all valid bits in one cycle
// row_pixels holds column 0 at bit 63 and is zero for every op but read
module sprite_frame_buffer_draw #(
	parameter int unsigned SCREEN_COLUMNS = 64,
	parameter int unsigned SCREEN_ROWS    = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	output logic                            done,
	input  logic [sfbd_pkg::OP_W-1:0]       opcode,
	input  logic [sfbd_pkg::COL_W-1:0]      pos_x,
	input  logic [sfbd_pkg::ROWIN_W-1:0]    pos_y,
	input  logic [sfbd_pkg::SPRITE_W-1:0]   row_bits,
	input  logic                            sprite_start,
	output logic                            collision,
	output logic [sfbd_pkg::PIX_W-1:0]      row_pixels
);
	import sfbd_pkg::*;

	// commands from the controller into the datapath
	sfbd_cmd_t cmd;

	// sequencer: idle, row read, modify and write back
	sfbd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// row memory with valid bits, xor and collision logic
	sfbd_datapath #(
		.SCREEN_COLUMNS (SCREEN_COLUMNS),
		.SCREEN_ROWS    (SCREEN_ROWS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.opcode       (opcode),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.row_bits     (row_bits),
		.sprite_start (sprite_start),
		.collision    (collision),
		.row_pixels   (row_pixels)
	);

endmodule

>>> tb/testbench.sv
// self-checking bench for the sprite frame buffer draw block
`timescale 1ns / 1ps

module testbench;

	import sfbd_pkg::*;

	localparam int unsigned COLS = 64;
	localparam int unsigned ROWS = 32;

	// the package names three opcodes; the fourth code does nothing
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// one request as it goes on the ports
	typedef struct {
		logic [OP_W-1:0]     op;
		logic [COL_W-1:0]    x;
		logic [ROWIN_W-1:0]  y;
		logic [SPRITE_W-1:0] bits;
		logic                sst;
	} draw_req_t;

	// directed row: request plus an optional hand-typed result
	typedef struct {
		logic [OP_W-1:0]     op;
		logic [COL_W-1:0]    x;
		logic [ROWIN_W-1:0]  y;
		logic [SPRITE_W-1:0] bits;
		logic                sst;
		bit                  typed;
		logic                col;
		logic [PIX_W-1:0]    pix;
	} dir_row_t;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                start        = 1'b0;
	logic [OP_W-1:0]     opcode       = OP_CLEAR;
	logic [COL_W-1:0]    pos_x        = '0;
	logic [ROWIN_W-1:0]  pos_y        = '0;
	logic [SPRITE_W-1:0] row_bits     = '0;
	logic                sprite_start = 1'b0;
	logic                busy;
	logic                done;
	logic                collision;
	logic [PIX_W-1:0]    row_pixels;

	// predictor state: screen image and collision flag
	logic [PIX_W-1:0] frame_rows [ROWS];
	logic             seen_collision;

	// results still owed by the block, oldest first
	logic             pending_collision [$];
	logic [PIX_W-1:0] pending_pixels    [$];

	int err_count     = 0;
	int request_count = 0;
	int checked_count = 0;
	int clear_count   = 0;
	int draw_count    = 0;
	int read_count    = 0;
	int collide_count = 0;
	bit quiet         = 1'b0;

	// directed part: reset state, extremes, wrap at both edges, clear and the
	// unused opcode with every other field high, collision set and cleared
	dir_row_t dir_rows [22] = '{
		'{OP_READ,   6'd0,  5'd0,  8'h00, 1'b0, 1'b1, 1'b0, 64'h0},
		'{OP_READ,   6'd63, 5'd31, 8'hFF, 1'b1, 1'b1, 1'b0, 64'h0},
		'{OP_DRAW,   6'd0,  5'd0,  8'hFF, 1'b1, 1'b1, 1'b0, 64'h0},
		'{OP_READ,   6'd0,  5'd0,  8'h00, 1'b0, 1'b1, 1'b0, 64'hFF00_0000_0000_0000},
		'{OP_DRAW,   6'd0,  5'd0,  8'h80, 1'b0, 1'b1, 1'b1, 64'h0},
		'{OP_READ,   6'd0,  5'd0,  8'h00, 1'b0, 1'b1, 1'b1, 64'h7F00_0000_0000_0000},
		'{OP_CLEAR,  6'd63, 5'd31, 8'hFF, 1'b1, 1'b1, 1'b1, 64'h0},
		'{OP_READ,   6'd0,  5'd0,  8'h00, 1'b1, 1'b1, 1'b1, 64'h0},
		'{OP_UNUSED, 6'd63, 5'd31, 8'hFF, 1'b1, 1'b1, 1'b1, 64'h0},
		'{OP_DRAW,   6'd0,  5'd5,  8'h00, 1'b1, 1'b1, 1'b0, 64'h0},
		'{OP_DRAW,   6'd60, 5'd31, 8'hFF, 1'b1, 1'b1, 1'b0, 64'h0},
		'{OP_READ,   6'd0,  5'd31, 8'h00, 1'b0, 1'b1, 1'b0, 64'hF000_0000_0000_000F},
		'{OP_DRAW,   6'd63, 5'd31, 8'h81, 1'b0, 1'b1, 1'b1, 64'h0},
		'{OP_READ,   6'd17, 5'd31, 8'h3C, 1'b0, 1'b0, 1'b0, 64'h0},
		'{OP_DRAW,   6'd4,  5'd31, 8'hAA, 1'b1, 1'b0, 1'b0, 64'h0},
		'{OP_DRAW,   6'd56, 5'd16, 8'h55, 1'b0, 1'b0, 1'b0, 64'h0},
		'{OP_READ,   6'd0,  5'd16, 8'h00, 1'b0, 1'b0, 1'b0, 64'h0},
		'{OP_DRAW,   6'd60, 5'd31, 8'hFF, 1'b1, 1'b0, 1'b0, 64'h0},
		'{OP_READ,   6'd0,  5'd31, 8'h00, 1'b0, 1'b0, 1'b0, 64'h0},
		'{OP_UNUSED, 6'd0,  5'd0,  8'h00, 1'b0, 1'b0, 1'b0, 64'h0},
		'{OP_CLEAR,  6'd0,  5'd0,  8'h00, 1'b0, 1'b0, 1'b0, 64'h0},
		'{OP_READ,   6'd0,  5'd31, 8'h00, 1'b0, 1'b1, 1'b1, 64'h0}
	};

	sprite_frame_buffer_draw #(
		.SCREEN_COLUMNS(COLS),
		.SCREEN_ROWS   (ROWS)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.done        (done),
		.opcode      (opcode),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.row_bits    (row_bits),
		.sprite_start(sprite_start),
		.collision   (collision),
		.row_pixels  (row_pixels)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// screen model: apply one request, return collision flag and read row
	task automatic apply_to_frame(input draw_req_t r, output logic col,
			output logic [PIX_W-1:0] pix);
		logic [PIX_W-1:0]   line;
		logic [COL_W-1:0]   c;
		logic [ROWIN_W-1:0] ry;
		ry  = ROWIN_W'(r.y % ROWS);
		pix = '0;
		case (r.op)
			OP_CLEAR: begin
				// collision flag survives a clear
				for (int i = 0; i < ROWS; i++)
					frame_rows[i] = '0;
			end
			OP_DRAW: begin
				line = frame_rows[ry];
				if (r.sst)
					seen_collision = 1'b0;
				for (int i = 0; i < SPRITE_W; i++) begin
					if (r.bits[SPRITE_W-1-i]) begin
						// 6-bit sum wraps past the right edge
						c = r.x + COL_W'(i);
						if (line[PIX_W-1-c])
							seen_collision = 1'b1;
						line[PIX_W-1-c] = ~line[PIX_W-1-c];
					end
				end
				frame_rows[ry] = line;
			end
			OP_READ: pix = frame_rows[ry];
			default: ;
		endcase
		col = seen_collision;
	endtask

	// drive one request and wait for the accepting edge; called right after
	// a rising edge, so start stays high across back-to-back requests
	task automatic issue_request(input draw_req_t r, input bit typed,
			input logic col_t, input logic [PIX_W-1:0] pix_t);
		int               gap;
		logic             col;
		logic [PIX_W-1:0] pix;
		gap = 0;
		if (!quiet)
			while ($urandom_range(99) < 6)
				gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start        <= 1'b1;
		opcode       <= r.op;
		pos_x        <= r.x;
		pos_y        <= r.y;
		row_bits     <= r.bits;
		sprite_start <= r.sst;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		// accepted at this edge
		apply_to_frame(r, col, pix);
		if (typed) begin
			col = col_t;
			pix = pix_t;
		end
		pending_collision.push_back(col);
		pending_pixels.push_back(pix);
		request_count++;
		case (r.op)
			OP_CLEAR: clear_count++;
			OP_DRAW:  draw_count++;
			OP_READ:  read_count++;
			default:  ;
		endcase
	endtask

	task automatic issue_plain(input logic [OP_W-1:0] op, input logic [COL_W-1:0] x,
			input logic [ROWIN_W-1:0] y, input logic [SPRITE_W-1:0] bits,
			input logic sst);
		draw_req_t r;
		r.op   = op;
		r.x    = x;
		r.y    = y;
		r.bits = bits;
		r.sst  = sst;
		issue_request(r, 1'b0, 1'b0, '0);
	endtask

	// result checker: done marks a one-cycle result that must be taken now
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_collision.size() == 0) begin
				$error("result with no request outstanding: collision %0b, row_pixels %h",
					collision, row_pixels);
				err_count++;
			end else begin
				logic             exp_col;
				logic [PIX_W-1:0] exp_pix;
				exp_col = pending_collision.pop_front();
				exp_pix = pending_pixels.pop_front();
				if (collision !== exp_col) begin
					$error("collision: expected %0b, got %0b", exp_col, collision);
					err_count++;
				end
				if (row_pixels !== exp_pix) begin
					$error("row_pixels: expected %h, got %h", exp_pix, row_pixels);
					err_count++;
				end
				checked_count++;
				if (collision === 1'b1)
					collide_count++;
			end
		end
	end

	// stimulus
	initial begin
		draw_req_t                    r;
		logic [SPRITE_W-1:0]          sprite [16];
		logic [COL_W-1:0]             sx;
		logic [ROWIN_W-1:0]           sy;
		int                           n;
		int                           pick;
		for (int i = 0; i < ROWS; i++)
			frame_rows[i] = '0;
		seen_collision = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k]) begin
			r.op   = dir_rows[k].op;
			r.x    = dir_rows[k].x;
			r.y    = dir_rows[k].y;
			r.bits = dir_rows[k].bits;
			r.sst  = dir_rows[k].sst;
			issue_request(r, dir_rows[k].typed, dir_rows[k].col, dir_rows[k].pix);
		end

		// random part: mostly whole sprites, some redrawn to erase them and
		// raise collision, reads of what was drawn, and a little noise
		while (request_count < 1875) begin
			// one long stretch with no idling at all
			quiet = (request_count >= 700) && (request_count < 1000);
			pick  = $urandom_range(99);
			if (pick < 60) begin
				n  = $urandom_range(1, 15);
				sx = COL_W'($urandom);
				sy = ROWIN_W'($urandom);
				for (int i = 0; i < n; i++)
					sprite[i] = SPRITE_W'($urandom);
				// a sprite now and then lacks its start mark
				for (int i = 0; i < n; i++)
					issue_plain(OP_DRAW, sx, sy + ROWIN_W'(i), sprite[i],
						(i == 0) && ($urandom_range(9) != 0));
				if ($urandom_range(1) == 1)
					for (int i = 0; i < n; i++)
						issue_plain(OP_DRAW, sx, sy + ROWIN_W'(i), sprite[i], i == 0);
				if ($urandom_range(2) == 0)
					for (int i = 0; i < n; i++)
						issue_plain(OP_READ, COL_W'($urandom), sy + ROWIN_W'(i),
							SPRITE_W'($urandom), 1'($urandom));
			end else if (pick < 85) begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					issue_plain(OP_READ, COL_W'($urandom), ROWIN_W'($urandom),
						SPRITE_W'($urandom), 1'($urandom));
			end else if (pick < 98) begin
				// loose rows and the unused code with random fields
				issue_plain(($urandom_range(3) == 0) ? OP_UNUSED : OP_DRAW,
					COL_W'($urandom), ROWIN_W'($urandom), SPRITE_W'($urandom),
					1'($urandom));
			end else begin
				issue_plain(OP_CLEAR, COL_W'($urandom), ROWIN_W'($urandom),
					SPRITE_W'($urandom), 1'($urandom));
			end
		end
		start <= 1'b0;

		while (pending_collision.size() != 0)
			@(posedge clk);
		// catch any stray result after the last one
		repeat (8) @(posedge clk);

		$display("%0d requests, %0d results checked: %0d clears, %0d draws, %0d reads",
			request_count, checked_count, clear_count, draw_count, read_count);
		$display("%0d results came back with collision set", collide_count);
		if (err_count == 0 && pending_collision.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// hard stop far beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("timeout: %0d results still outstanding", pending_collision.size());
		$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/sfbd_pkg.sv
hw/rtl/sfbd_ctrl.sv
hw/rtl/sfbd_datapath.sv
hw/rtl/sprite_frame_buffer_draw.sv
tb/testbench.sv
